@@ hdl/usls_pkg.sv @@
// Shared types and constants for the unsorted list store.
`timescale 1ns / 1ps

package usls_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 4;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  read_value;
        logic [IDX_W-1:0]   found_index;
        logic [CNT_W-1:0]   entry_count;
    } res_t;

endpackage

@@ hdl/usls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module usls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/usls_ctrl.sv @@
// Sequencer: append, indexed read, linear scan and compaction over the entry RAM.
`timescale 1ns / 1ps

module usls_ctrl #(
    parameter int DEPTH = usls_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  usls_pkg::op_t               req_op,
    input  logic [usls_pkg::DATA_W-1:0] req_value,
    input  logic [usls_pkg::POS_W-1:0]  req_position,
    output logic                        res_valid,
    output usls_pkg::res_t              res,
    input  logic                        out_free,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [usls_pkg::DATA_W-1:0] mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  logic [usls_pkg::DATA_W-1:0] mem_rdata
);
    import usls_pkg::*;

    localparam int EW = CW + 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDWAIT = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_HOLD   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    op_t               op_reg, op_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [AW-1:0]     idx_reg, idx_next;
    res_t              hold_reg, hold_next;

    logic              fin;
    status_t           fin_status;
    logic [DATA_W-1:0] fin_rd;
    logic [IDX_W-1:0]  fin_idx;
    res_t              fin_res;
    logic [EW-1:0]     idx1_ext, idx2_ext, count_ext;

    assign idx1_ext  = EW'(idx_reg) + EW'(1);
    assign idx2_ext  = EW'(idx_reg) + EW'(2);
    assign count_ext = EW'(count_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        op_next    = op_reg;
        value_next = value_reg;
        idx_next   = idx_reg;
        hold_next  = hold_reg;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_rd     = '0;
        fin_idx    = '0;
        req_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = AW'(idx1_ext);

        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    case (req_op)
                        OP_APPEND: begin
                            fin = 1'b1;
                            if (count_reg == CW'(DEPTH)) begin
                                fin_status = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = req_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_READ: begin
                            mem_raddr = AW'(req_position);
                            if (PW'(req_position) >= PW'(count_reg)) begin
                                fin        = 1'b1;
                                fin_status = ST_RANGE;
                            end else begin
                                state_next = S_RDWAIT;
                            end
                        end
                        OP_FIND, OP_REMOVE: begin
                            mem_raddr  = '0;
                            idx_next   = '0;
                            op_next    = req_op;
                            value_next = req_value;
                            if (count_reg == '0) begin
                                fin        = 1'b1;
                                fin_status = ST_NOTFOUND;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT: begin
                fin    = 1'b1;
                fin_rd = mem_rdata;
            end
            S_SCAN: begin
                // rdata holds the entry at idx_reg; idx_reg + 1 is already being fetched
                if (mem_rdata == value_reg) begin
                    if (op_reg == OP_FIND) begin
                        fin     = 1'b1;
                        fin_idx = IDX_W'(idx_reg);
                    end else if (idx1_ext < count_ext) begin
                        state_next = S_SHIFT;
                    end else begin
                        fin        = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end else if (idx1_ext >= count_ext) begin
                    fin        = 1'b1;
                    fin_status = ST_NOTFOUND;
                end else begin
                    idx_next = AW'(idx1_ext);
                end
            end
            S_SHIFT: begin
                // move the word at idx_reg + 1 down into the hole at idx_reg
                mem_we    = 1'b1;
                mem_raddr = AW'(idx2_ext);
                if (idx2_ext < count_ext) begin
                    idx_next = AW'(idx1_ext);
                end else begin
                    fin        = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        fin_res.status      = fin_status;
        fin_res.read_value  = fin_rd;
        fin_res.found_index = fin_idx;
        fin_res.entry_count = CNT_W'(count_next);

        if (fin) begin
            if (out_free) begin
                state_next = S_IDLE;
            end else begin
                state_next = S_HOLD;
                hold_next  = fin_res;
            end
        end
    end

    assign res_valid = fin || (state_reg == S_HOLD);
    assign res       = (state_reg == S_HOLD) ? hold_reg : fin_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        op_reg    <= op_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        hold_reg  <= hold_next;
    end

endmodule

@@ hdl/unsorted_list_store_core.sv @@
// Top level of the unsorted list store: request port, entry RAM, sequencer, result register.
`timescale 1ns / 1ps

// Ordered store of up to DEPTH signed 32-bit values, kept compact in insertion order.
// Requests enter on the s_ stream: s_tuser carries the operation (append, read at
// index, find, remove first match), s_tdata the value and the read index. Each
// request yields exactly one result word on the m_ stream: m_tuser is the status,
// m_tdata the read value, the found index and the entry count after the operation.
// One request is worked on at a time; the next is taken once the previous result
// has been handed to the result register, even while that word still waits.
// Append, and any request that fails at once, is answered straight from the idle
// state; a read waits for the registered RAM data; find scans from index 0 up to the
// first match or the last entry; remove scans the same way and then moves each
// later entry down by one to close the gap. The entry RAM has one read and one
// write port, so the scan and the compaction each move one entry per cycle.
// Reset (aresetn low, synchronous) empties the store and drops any pending result.
// RAM contents need no clearing. When m_tready is low the result word holds and
// at most one further result waits inside, stalling the request side.

module unsorted_list_store_core #(
    parameter int DEPTH = usls_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], position [35:32], zero pad
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value [31:0], found_index [35:32],
                                   // entry_count [40:36], zero pad
    output logic [1:0]  m_tuser    // status [1:0]
);
    import usls_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              res_valid;
    res_t              res;
    logic              out_free;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              m_valid_reg;
    res_t              m_res_reg;

    assign out_free = !m_valid_reg || m_tready;

    usls_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_op       (op_t'(s_tuser)),
        .req_value    (s_tdata[31:0]),
        .req_position (s_tdata[35:32]),
        .res_valid    (res_valid),
        .res          (res),
        .out_free     (out_free),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    usls_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // load a new word when the slot is empty or its word is being taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && out_free) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_res_reg.entry_count, m_res_reg.found_index,
                       m_res_reg.read_value};
    assign m_tuser  = m_res_reg.status;

endmodule

@@ hdl/usls_chk.sv @@
// Port-level checks on the result stream of the unsorted list store, bound to the top.
`timescale 1ns / 1ps

module usls_chk #(
    parameter int DEPTH = usls_pkg::DEPTH_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import usls_pkg::*;

    // a full report only comes with a store holding DEPTH entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[40:36] == CNT_W'(DEPTH)))
        else $error("full status with entry count below depth");

    // read data only on a successful request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[31:0] != '0) |-> (m_tuser == ST_OK))
        else $error("nonzero read value with failing status");

    // found index only on a successful request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[35:32] != '0) |-> (m_tuser == ST_OK))
        else $error("nonzero found index with failing status");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result word changed while stalled");

endmodule

bind unsorted_list_store_core usls_chk #(
    .DEPTH(DEPTH)
) u_usls_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/testbench.sv @@
// Testbench for unsorted_list_store_core: directed table plus random requests vs a predictor.
`timescale 1ns / 1ps

module testbench;
    import usls_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    unsorted_list_store_core #(.DEPTH(STORE_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    typedef struct {
        op_t         op;
        logic [31:0] value;
        logic [3:0]  pos;
        bit          typed;
        res_t        want;
    } dir_row_t;

    // Shadow copy of the store
    logic [31:0] store_words [STORE_DEPTH];
    int          store_count = 0;

    res_t     expected_results [$];
    dir_row_t dir_rows [$];
    int       mismatches  = 0;
    bit       no_idle     = 1'b0;
    bit       hold_off_req = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Apply one request to the shadow store and return the word it should produce.
    function automatic res_t apply_request(op_t op, logic [31:0] v, logic [3:0] pos);
        res_t r;
        int   hit;
        r.status      = ST_OK;
        r.read_value  = '0;
        r.found_index = '0;
        hit = store_count;
        if (op == OP_FIND || op == OP_REMOVE) begin
            for (int i = store_count - 1; i >= 0; i--) begin
                if (store_words[i] == v) hit = i;
            end
        end
        case (op)
            OP_APPEND: begin
                if (store_count >= STORE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    store_words[store_count] = v;
                    store_count++;
                end
            end
            OP_READ: begin
                if (int'(pos) >= store_count) r.status = ST_RANGE;
                else r.read_value = store_words[pos];
            end
            OP_FIND: begin
                if (hit >= store_count) r.status = ST_NOTFOUND;
                else r.found_index = hit[3:0];
            end
            default: begin
                if (hit >= store_count) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    // close the gap, keep order
                    for (int i = hit; i + 1 < store_count; i++) begin
                        store_words[i] = store_words[i + 1];
                    end
                    store_count--;
                end
            end
        endcase
        r.entry_count = store_count[4:0];
        return r;
    endfunction

    function automatic void add_row(op_t op, logic [31:0] v, logic [3:0] pos, bit typed,
                                    status_t st, logic [31:0] rv, logic [3:0] idx,
                                    logic [4:0] cnt);
        dir_row_t row;
        row.op    = op;
        row.value = v;
        row.pos   = pos;
        row.typed = typed;
        row.want  = '{status: st, read_value: rv, found_index: idx, entry_count: cnt};
        dir_rows.push_back(row);
    endfunction

    task automatic issue_request(op_t op, logic [31:0] v, logic [3:0] pos, bit typed,
                                 res_t want);
        res_t predicted;
        int   gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, pos, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_request(op, v, pos);
        expected_results.push_back(typed ? want : predicted);
        gap = no_idle ? 0 : $urandom_range(0, 3);
        // keep tvalid up for back-to-back words
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver: random stall per word, long hold-off on request.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d data %h", m_tuser, m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser != want.status || m_tdata[31:0] != want.read_value ||
                    m_tdata[35:32] != want.found_index ||
                    m_tdata[40:36] != want.entry_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d rv %h idx %0d cnt %0d, got st %0d rv %h idx %0d cnt %0d",
                                 want.status, want.read_value, want.found_index,
                                 want.entry_count, m_tuser, m_tdata[31:0], m_tdata[35:32],
                                 m_tdata[40:36]);
                end
            end
        end
    end

    initial begin
        logic [31:0] value_pool [8];
        op_t         op;
        logic [31:0] v;
        logic [3:0]  p;
        bit          growing;
        int          r;
        res_t        none;

        none = '0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < 8; i++) value_pool[i] = $urandom;

        // empty store, both extremes, duplicates, then fill to full
        add_row(OP_READ,   32'h0,         4'd0,  1, ST_RANGE,    32'h0, 4'd0, 5'd0);
        add_row(OP_FIND,   32'h0,         4'd0,  1, ST_NOTFOUND, 32'h0, 4'd0, 5'd0);
        add_row(OP_REMOVE, 32'h0,         4'd0,  1, ST_NOTFOUND, 32'h0, 4'd0, 5'd0);
        add_row(OP_APPEND, 32'h8000_0000, 4'd15, 1, ST_OK,       32'h0, 4'd0, 5'd1);
        add_row(OP_APPEND, 32'h7FFF_FFFF, 4'd0,  1, ST_OK,       32'h0, 4'd0, 5'd2);
        add_row(OP_READ,   32'h0,         4'd0,  1, ST_OK, 32'h8000_0000, 4'd0, 5'd2);
        add_row(OP_READ,   32'hFFFF_FFFF, 4'd15, 1, ST_RANGE,    32'h0, 4'd0, 5'd2);
        add_row(OP_FIND,   32'h7FFF_FFFF, 4'd0,  1, ST_OK,       32'h0, 4'd1, 5'd2);
        add_row(OP_REMOVE, 32'h8000_0000, 4'd0,  1, ST_OK,       32'h0, 4'd0, 5'd1);
        add_row(OP_APPEND, 32'h7FFF_FFFF, 4'd0,  1, ST_OK,       32'h0, 4'd0, 5'd2);
        for (int k = 1; k < 15; k++)
            add_row(OP_APPEND, k * 32'h1357_9BDF ^ 32'hFFFF_0000, 4'(k), 1, ST_OK,
                    32'h0, 4'd0, 5'(k + 2));
        add_row(OP_APPEND, 32'h1,         4'd0,  1, ST_FULL,     32'h0, 4'd0, 5'd16);
        add_row(OP_READ,   32'h0,         4'd15, 0, ST_OK,       32'h0, 4'd0, 5'd0);
        add_row(OP_FIND,   32'h7FFF_FFFF, 4'd0,  1, ST_OK,       32'h0, 4'd0, 5'd16);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            issue_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].pos,
                          dir_rows[i].typed, dir_rows[i].want);

        growing = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n == 500 || n == 1200) hold_off_req = 1'b1;
            if (store_count == 0) growing = 1'b1;
            else if (store_count == STORE_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;

            r = $urandom_range(0, 99);
            if (growing)
                op = (r < 45) ? OP_APPEND : (r < 65) ? OP_READ : (r < 82) ? OP_FIND : OP_REMOVE;
            else
                op = (r < 15) ? OP_APPEND : (r < 35) ? OP_READ : (r < 50) ? OP_FIND : OP_REMOVE;

            // mostly look up values that are actually stored
            if ((op == OP_FIND || op == OP_REMOVE) && store_count > 0 &&
                $urandom_range(0, 9) < 6)
                v = store_words[$urandom_range(0, store_count - 1)];
            else if ($urandom_range(0, 3) == 0)
                v = $urandom;
            else
                v = value_pool[$urandom_range(0, 7)];

            if (store_count > 0 && $urandom_range(0, 9) < 7)
                p = 4'($urandom_range(0, store_count - 1));
            else
                p = 4'($urandom_range(0, 15));

            issue_request(op, v, p, 1'b0, none);
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
